// File: rtl/vet_pkg.sv
// Package for the voxel energy tally: widths, request codes, saturation limits.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package vet_pkg;
    localparam int VOXEL_COUNT = 65536;
    localparam int VOX_W = $clog2(VOXEL_COUNT);
    localparam int CNT_W = VOX_W + 1;

    localparam logic [2:0] REQ_DEPOSIT = 3'd0;
    localparam logic [2:0] REQ_SOURCE  = 3'd1;
    localparam logic [2:0] REQ_ACCUM   = 3'd2;
    localparam logic [2:0] REQ_LIST    = 3'd3;
    localparam logic [2:0] REQ_SUMS    = 3'd4;
    localparam logic [2:0] REQ_RESET   = 3'd5;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

    // one word of per-voxel state: hit flag, batch, sum, square sum
    typedef struct packed {
        logic        hit;
        logic [47:0] batch;
        logic [47:0] sum;
        logic [63:0] sq;
    } t_vox;
    localparam int VOX_WORD_W = $bits(t_vox);
endpackage
`default_nettype wire

// File: rtl/vet_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module vet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/voxel_energy_tally_with_footprint.sv
// Voxel energy tally with footprint list: sequencer around two memories.
// Depends on vet_pkg and vet_ram.
//
//  channel | dir | handshake             | payload
//  request | in  | i_valid / o_ready     | i_req_type i_voxel i_weight i_energy
//          |     |                       | i_scale i_list_position
//  result  | out | o_valid / i_ready     | o_list_entry o_footprint_count o_sum_energy
//          |     |                       | o_sum_energy_squared o_source_total o_saturated
//
// From the accepting edge a deposit reads the voxel word, forms the product in
// two multiply halves, adds and writes back, then raises the result. Accumulate
// walks every footprint entry (list read, voxel read, multiply passes on the one
// shared 24x24 multiplier, write back). Footprint reset walks every entry too.
// A list read looks the entry up, after a full sweep of the voxel words when
// the list changed. After reset a clearing pass writes every voxel word
// with o_ready low. A result waits in the output register; the next request
// is taken once it has been delivered.
`timescale 1ns / 1ps
`default_nettype none
module voxel_energy_tally_with_footprint (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [2:0]  i_req_type,
    input  wire  [15:0] i_voxel,
    input  wire  [15:0] i_weight,
    input  wire  [31:0] i_energy,
    input  wire  [23:0] i_scale,
    input  wire  [15:0] i_list_position,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [15:0] o_list_entry,
    output logic [16:0] o_footprint_count,
    output logic [47:0] o_sum_energy,
    output logic [63:0] o_sum_energy_squared,
    output logic [47:0] o_source_total,
    output logic        o_saturated
);
    localparam int VW = vet_pkg::VOX_W;
    localparam int CW = vet_pkg::CNT_W;
    localparam int WW = vet_pkg::VOX_WORD_W;

    // sequencer states
    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DRD   = 5'd2;
    localparam logic [4:0] S_DMUL  = 5'd3;
    localparam logic [4:0] S_DWR   = 5'd4;
    localparam logic [4:0] S_SRC   = 5'd5;
    localparam logic [4:0] S_ARDL  = 5'd6;
    localparam logic [4:0] S_ARDV  = 5'd7;
    localparam logic [4:0] S_AM0   = 5'd8;
    localparam logic [4:0] S_AM1   = 5'd9;
    localparam logic [4:0] S_AM2   = 5'd10;
    localparam logic [4:0] S_AM3   = 5'd11;
    localparam logic [4:0] S_AWR   = 5'd12;
    localparam logic [4:0] S_SRTR  = 5'd13;
    localparam logic [4:0] S_SRTW  = 5'd14;
    localparam logic [4:0] S_LRD   = 5'd15;
    localparam logic [4:0] S_LOUT  = 5'd16;
    localparam logic [4:0] S_VRD   = 5'd17;
    localparam logic [4:0] S_VOUT  = 5'd18;
    localparam logic [4:0] S_RRDL  = 5'd19;
    localparam logic [4:0] S_RRDV  = 5'd20;
    localparam logic [4:0] S_RWR   = 5'd21;
    localparam logic [4:0] S_DONE  = 5'd22;
    localparam logic [4:0] S_AM4   = 5'd23;
    localparam logic [4:0] S_AADD  = 5'd24;

    logic [4:0]  r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt;      // sweep / walk counter
    logic [CW-1:0] r_n, n_n;          // sort write position
    logic [CW-1:0] r_size, n_size;
    logic        r_order, n_order;
    logic [47:0] r_src, n_src;
    logic        r_sat, n_sat;
    logic        r_oval, n_oval;
    logic [15:0] r_oent, n_oent;
    logic [47:0] r_ose, n_ose;
    logic [63:0] r_ose2, n_ose2;

    // latched request
    logic [2:0]  r_req;
    logic [VW-1:0] r_vox;
    logic [15:0] r_wgt;
    logic [31:0] r_eng;
    logic [23:0] r_scl;
    logic [15:0] r_pos;

    // arithmetic registers
    logic [47:0] r_prod, n_prod;
    logic [63:0] r_acc, n_acc;
    logic [47:0] r_e, n_e;
    logic [VW-1:0] r_cur, n_cur;
    vet_pkg::t_vox r_w, n_w;

    // voxel memory and list memory ports
    logic          vm_we, lm_we;
    logic [VW-1:0] vm_wa, vm_ra, lm_wa, lm_ra;
    vet_pkg::t_vox vm_wd, vm_rd;
    logic [15:0]   lm_wd, lm_rd;

    vet_ram #(.WIDTH(WW), .DEPTH(vet_pkg::VOXEL_COUNT)) u_vox (
        .i_clk(i_clk), .i_we(vm_we), .i_waddr(vm_wa), .i_wdata(vm_wd),
        .i_raddr(vm_ra), .o_rdata(vm_rd)
    );
    vet_ram #(.WIDTH(16), .DEPTH(vet_pkg::VOXEL_COUNT)) u_list (
        .i_clk(i_clk), .i_we(lm_we), .i_waddr(lm_wa), .i_wdata(lm_wd),
        .i_raddr(lm_ra), .o_rdata(lm_rd)
    );

    wire acc_in = i_valid && o_ready;
    assign o_ready = (r_st == S_IDLE) && !r_oval;

    // shared multiplier: 24x24
    logic [23:0] m_a, m_b;
    logic [47:0] m_p;
    assign m_p = m_a * m_b;

    logic [48:0] add48_s;
    logic [64:0] add64_s;
    logic [63:0] add64_b;
    logic [47:0] add48_b;
    assign add48_s = {1'b0, r_w.sum} + {1'b0, add48_b};
    assign add64_s = {1'b0, r_w.sq} + {1'b0, add64_b};

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_n = r_n; n_size = r_size;
        n_order = r_order; n_src = r_src; n_sat = r_sat;
        n_oval = r_oval; n_oent = r_oent; n_ose = r_ose; n_ose2 = r_ose2;
        n_prod = r_prod; n_acc = r_acc; n_e = r_e; n_cur = r_cur; n_w = r_w;
        vm_we = 1'b0; vm_wa = r_cur; vm_wd = r_w; vm_ra = r_vox;
        lm_we = 1'b0; lm_wa = r_n[VW-1:0]; lm_wd = 16'(r_cur); lm_ra = r_cnt[VW-1:0];
        m_a = 24'(r_wgt); m_b = r_eng[23:0];
        add48_b = r_e;
        add64_b = r_acc;
        if (r_oval && i_ready) begin
            n_oval = 1'b0;
        end
        case (r_st)
            S_CLR: begin
                vm_we = 1'b1; vm_wa = r_cnt[VW-1:0]; vm_wd = '0;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(vet_pkg::VOXEL_COUNT - 1)) begin
                    n_st = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc_in) begin
                    n_ose = '0; n_ose2 = '0; n_oent = '0; n_cnt = '0; n_n = '0;
                    case (i_req_type)
                        vet_pkg::REQ_DEPOSIT: n_st = S_DRD;
                        vet_pkg::REQ_SOURCE:  n_st = S_SRC;
                        vet_pkg::REQ_ACCUM:   n_st = S_ARDL;
                        vet_pkg::REQ_LIST:    n_st = r_order ? S_LRD : S_SRTR;
                        vet_pkg::REQ_SUMS:    n_st = S_VRD;
                        vet_pkg::REQ_RESET:   n_st = S_RRDL;
                        default:              n_st = S_DONE;
                    endcase
                end
            end
            // deposit: voxel word arrives next cycle; product in two halves
            S_DRD: begin
                n_st = S_DMUL;
                n_prod = m_p;   // weight * energy[23:0]
            end
            S_DMUL: begin
                n_w = vm_rd;
                m_b = 24'(r_eng[31:24]);
                // full product = low + (high << 24), then >> 14
                n_acc = 64'(r_prod) + {16'd0, m_p[23:0], 24'd0};
                n_cur = r_vox;
                n_st = S_DWR;
            end
            S_DWR: begin
                add48_b = r_w.batch;
                n_e = 48'(r_acc >> 14);
                vm_we = 1'b1;
                vm_wd = r_w;
                // batch + deposit, saturate
                if ({1'b0, r_w.batch} + {1'b0, 48'(r_acc >> 14)} > {1'b0, vet_pkg::MAX48}) begin
                    vm_wd.batch = vet_pkg::MAX48; n_sat = 1'b1;
                end else begin
                    vm_wd.batch = r_w.batch + 48'(r_acc >> 14);
                end
                if (!r_w.hit && r_size < CW'(vet_pkg::VOXEL_COUNT)) begin
                    vm_wd.hit = 1'b1;
                    lm_we = 1'b1; lm_wa = r_size[VW-1:0]; lm_wd = 16'(r_vox);
                    n_size = r_size + 1'b1;
                    n_order = 1'b0;
                end
                n_st = S_DONE;
            end
            S_SRC: begin
                if ({1'b0, r_src} + {17'd0, r_eng} > {1'b0, vet_pkg::MAX48}) begin
                    n_src = vet_pkg::MAX48; n_sat = 1'b1;
                end else begin
                    n_src = r_src + 48'(r_eng);
                end
                n_st = S_DONE;
            end
            // accumulate walk: list read, voxel read, multiply passes, write
            S_ARDL: begin
                if (r_cnt >= r_size) begin
                    n_st = S_DONE;
                end else begin
                    n_st = S_ARDV;
                end
            end
            S_ARDV: begin
                n_cur = lm_rd[VW-1:0];
                vm_ra = lm_rd[VW-1:0];
                n_st = S_AM0;
            end
            S_AM0: begin
                n_w = vm_rd;
                m_a = vm_rd.batch[23:0]; m_b = r_scl;
                n_prod = m_p;
                n_st = S_AM1;
            end
            S_AM1: begin
                m_a = r_w.batch[47:24]; m_b = r_scl;
                // e = (hi << 8) + (lo >> 16), up to 56 bits
                n_acc = {8'd0, m_p, 8'd0} + 64'(r_prod >> 16);
                n_st = S_AM2;
            end
            S_AM2: begin
                if (r_acc > 64'(vet_pkg::MAX48)) begin
                    n_e = vet_pkg::MAX48; n_sat = 1'b1;
                end else begin
                    n_e = r_acc[47:0];
                end
                n_st = S_AM3;
            end
            S_AM3: begin
                // square: e = h*2^16 + l, e below 2^32 when not saturated
                m_a = 24'(r_e[15:0]); m_b = 24'(r_e[15:0]);
                n_acc = 64'(m_p);
                if (r_e > 48'hFFFF_FFFF) begin
                    n_sat = 1'b1;
                end
                n_st = S_AM4;
            end
            S_AM4: begin
                m_a = 24'(r_e[31:16]); m_b = 24'(r_e[15:0]);
                n_acc = r_acc + {15'd0, m_p[31:0], 17'd0};
                n_st = S_AADD;
            end
            S_AADD: begin
                m_a = 24'(r_e[31:16]); m_b = 24'(r_e[31:16]);
                n_acc = (r_e > 48'hFFFF_FFFF) ? vet_pkg::MAX64
                                              : r_acc + {m_p[31:0], 32'd0};
                n_st = S_AWR;
            end
            S_AWR: begin
                vm_we = 1'b1;
                vm_wd = r_w;
                vm_wd.batch = '0;
                if (add48_s[48]) begin
                    vm_wd.sum = vet_pkg::MAX48; n_sat = 1'b1;
                end else begin
                    vm_wd.sum = add48_s[47:0];
                end
                if (add64_s[64]) begin
                    vm_wd.sq = vet_pkg::MAX64; n_sat = 1'b1;
                end else begin
                    vm_wd.sq = add64_s[63:0];
                end
                n_cnt = r_cnt + 1'b1;
                lm_ra = n_cnt[VW-1:0];
                n_st = S_ARDL;
            end
            // sort: sweep all voxel words, collect hit voxels in order
            S_SRTR: begin
                vm_ra = r_cnt[VW-1:0];
                n_cur = r_cnt[VW-1:0];
                n_st = S_SRTW;
            end
            S_SRTW: begin
                if (vm_rd.hit && r_n < r_size) begin
                    lm_we = 1'b1; lm_wa = r_n[VW-1:0]; lm_wd = 16'(r_cur);
                    n_n = r_n + 1'b1;
                end
                n_cnt = r_cnt + 1'b1;
                vm_ra = n_cnt[VW-1:0];
                n_cur = n_cnt[VW-1:0];
                if (r_cnt == CW'(vet_pkg::VOXEL_COUNT - 1)) begin
                    n_order = 1'b1;
                    n_st = S_LRD;
                end
            end
            S_LRD: begin
                lm_ra = r_pos[VW-1:0];
                n_st = S_LOUT;
            end
            S_LOUT: begin
                n_oent = (CW'(r_pos) < r_size) ? lm_rd : 16'd0;
                n_st = S_DONE;
            end
            S_VRD: begin
                n_st = S_VOUT;
            end
            S_VOUT: begin
                n_ose = vm_rd.sum; n_ose2 = vm_rd.sq;
                n_st = S_DONE;
            end
            // footprint reset walk
            S_RRDL: begin
                n_st = (r_cnt >= r_size) ? S_DONE : S_RRDV;
            end
            S_RRDV: begin
                n_cur = lm_rd[VW-1:0];
                vm_ra = lm_rd[VW-1:0];
                n_st = S_RWR;
            end
            S_RWR: begin
                vm_we = 1'b1;
                vm_wd = vm_rd;
                vm_wd.hit = 1'b0; vm_wd.sum = '0; vm_wd.sq = '0;
                n_cnt = r_cnt + 1'b1;
                lm_ra = n_cnt[VW-1:0];
                if (r_cnt + 1'b1 >= r_size) begin
                    n_size = '0; n_order = 1'b1;
                    n_st = S_DONE;
                end else begin
                    n_st = S_RRDL;
                end
            end
            S_DONE: begin
                n_oval = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_cnt <= '0; r_n <= '0; r_size <= '0;
            r_order <= 1'b1; r_src <= '0; r_sat <= 1'b0; r_oval <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_n <= n_n; r_size <= n_size;
            r_order <= n_order; r_src <= n_src; r_sat <= n_sat; r_oval <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_req <= i_req_type; r_vox <= i_voxel[VW-1:0]; r_wgt <= i_weight;
            r_eng <= i_energy; r_scl <= i_scale; r_pos <= i_list_position;
        end
        r_oent <= n_oent; r_ose <= n_ose; r_ose2 <= n_ose2;
        r_prod <= n_prod; r_acc <= n_acc; r_e <= n_e; r_cur <= n_cur; r_w <= n_w;
    end

    assign o_valid = r_oval;
    assign o_list_entry = r_oent;
    assign o_footprint_count = r_size;
    assign o_sum_energy = r_ose;
    assign o_sum_energy_squared = r_ose2;
    assign o_source_total = r_src;
    assign o_saturated = r_sat;

    // checks
    a_size_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= CW'(vet_pkg::VOXEL_COUNT)) else $error("footprint size overflow");
    a_sat_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |=> r_sat) else $error("saturation flag cleared");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> !o_ready) else $error("request taken with result pending");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_DONE) |=> r_oval) else $error("result not raised");
    a_reset_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_RRDL && r_cnt >= r_size) |-> r_size == '0 || r_req == vet_pkg::REQ_RESET)
        else $error("reset walk state mismatch");
endmodule
`default_nettype wire

// File: sim/tb.sv
// Testbench for voxel_energy_tally_with_footprint: random and directed requests,
// an in-bench predictor of the tally state, and an in-order result checker.
// Depends on vet_pkg and the RTL of the top level.
`timescale 1ns / 1ps
module tb;

    localparam longint CYCLE_LIMIT = 4000000;
    localparam int     N_RANDOM    = 1500;

    typedef struct {
        logic [2:0]  rt;
        logic [15:0] vox;
        logic [15:0] wt;
        logic [31:0] en;
        logic [23:0] sc;
        logic [15:0] pos;
        logic        drain_first;  // wait until every result is back
    } t_req;

    typedef struct {
        logic [15:0] entry;
        logic [16:0] cnt;
        logic [47:0] se;
        logic [63:0] se2;
        logic [47:0] src;
        logic        sat;
    } t_tally;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_req_type;
    logic [15:0] i_voxel;
    logic [15:0] i_weight;
    logic [31:0] i_energy;
    logic [23:0] i_scale;
    logic [15:0] i_list_position;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_list_entry;
    logic [16:0] o_footprint_count;
    logic [47:0] o_sum_energy;
    logic [63:0] o_sum_energy_squared;
    logic [47:0] o_source_total;
    logic        o_saturated;

    voxel_energy_tally_with_footprint uut (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // tally shadow state
    bit [47:0] batch_mem  [0:65535];
    bit [47:0] esum_mem   [0:65535];
    bit [63:0] sqsum_mem  [0:65535];
    bit        hit_mem    [0:65535];
    int        footprint  [$];
    bit        fp_sorted  = 1'b1;
    bit [47:0] src_total  = '0;
    bit        sat_sticky = 1'b0;

    t_req   pending_reqs [$];
    t_tally tally_expect [$];
    t_req   cur;
    int     n_accepted = 0;
    int     errors     = 0;
    longint cycles     = 0;

    function automatic logic [47:0] sat_add48(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > {1'b0, vet_pkg::MAX48}) begin
            sat_sticky = 1'b1;
            return vet_pkg::MAX48;
        end
        return s[47:0];
    endfunction

    function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[64]) begin
            sat_sticky = 1'b1;
            return vet_pkg::MAX64;
        end
        return s[63:0];
    endfunction

    // apply one request to the shadow state and return its result
    function automatic t_tally tally_step(t_req r);
        t_tally      t;
        logic [47:0] d;
        logic [71:0] prod;
        logic [47:0] e;
        logic [63:0] sq;
        int          v;
        t = '{default: '0};
        case (r.rt)
            vet_pkg::REQ_DEPOSIT: begin
                d = 48'((64'(r.wt) * 64'(r.en)) >> 14);
                batch_mem[r.vox] = sat_add48(batch_mem[r.vox], d);
                if (!hit_mem[r.vox] && footprint.size() < vet_pkg::VOXEL_COUNT) begin
                    hit_mem[r.vox] = 1'b1;
                    footprint.push_back(int'(r.vox));
                    fp_sorted = 1'b0;
                end
            end
            vet_pkg::REQ_SOURCE: src_total = sat_add48(src_total, 48'(r.en));
            vet_pkg::REQ_ACCUM: begin
                foreach (footprint[n]) begin
                    v = footprint[n];
                    prod = 72'(batch_mem[v]) * 72'(r.sc);
                    prod = prod >> 16;
                    if (prod > 72'(vet_pkg::MAX48)) begin
                        sat_sticky = 1'b1;
                        e = vet_pkg::MAX48;
                    end else begin
                        e = prod[47:0];
                    end
                    if (e > 48'hFFFF_FFFF) begin
                        sat_sticky = 1'b1;
                        sq = vet_pkg::MAX64;
                    end else begin
                        sq = 64'(e) * 64'(e);
                    end
                    esum_mem[v]  = sat_add48(esum_mem[v], e);
                    sqsum_mem[v] = sat_add64(sqsum_mem[v], sq);
                    batch_mem[v] = '0;
                end
            end
            vet_pkg::REQ_LIST: begin
                if (!fp_sorted) begin
                    footprint.sort();
                    fp_sorted = 1'b1;
                end
                if (int'(r.pos) < footprint.size())
                    t.entry = 16'(footprint[r.pos]);
            end
            vet_pkg::REQ_SUMS: begin
                t.se  = esum_mem[r.vox];
                t.se2 = sqsum_mem[r.vox];
            end
            vet_pkg::REQ_RESET: begin
                foreach (footprint[n]) begin
                    esum_mem[footprint[n]]  = '0;
                    sqsum_mem[footprint[n]] = '0;
                    hit_mem[footprint[n]]   = 1'b0;
                end
                footprint.delete();
                fp_sorted = 1'b1;
            end
            default: ;
        endcase
        t.cnt = 17'(footprint.size());
        t.src = src_total;
        t.sat = sat_sticky;
        return t;
    endfunction

    // idle profile: none, sender 76%, receiver 76%, both 32%
    function automatic int phase_now();
        return (n_accepted / 150) % 4;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                tally_expect.push_back(tally_step(cur));
                n_accepted = n_accepted + 1;
            end
            if (i_valid && !o_ready) begin
                // hold the request as offered
            end else if (pending_reqs.size() != 0
                         && !(pending_reqs[0].drain_first
                              && (tally_expect.size() != 0 || i_valid))
                         && !((phase_now() == 1 && $urandom_range(0, 99) < 76)
                              || (phase_now() == 3 && $urandom_range(0, 99) < 32))) begin
                cur = pending_reqs.pop_front();
                i_valid         <= 1'b1;
                i_req_type      <= cur.rt;
                i_voxel         <= cur.vox;
                i_weight        <= cur.wt;
                i_energy        <= cur.en;
                i_scale         <= cur.sc;
                i_list_position <= cur.pos;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, once, so the block backs up into its input
    int hold_cycles = 0;
    bit hold_done   = 1'b0;
    always @(posedge i_clk) begin
        if (!hold_done && n_accepted >= 400) begin
            hold_cycles <= 3000;
            hold_done   <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_tally exp_t;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (tally_expect.size() == 0) begin
                    $error("unexpected result: entry %0h count %0d", o_list_entry,
                           o_footprint_count);
                    errors++;
                end else begin
                    exp_t = tally_expect.pop_front();
                    if (o_list_entry !== exp_t.entry) begin
                        $error("list_entry exp %0h got %0h", exp_t.entry, o_list_entry);
                        errors++;
                    end
                    if (o_footprint_count !== exp_t.cnt) begin
                        $error("footprint_count exp %0d got %0d", exp_t.cnt,
                               o_footprint_count);
                        errors++;
                    end
                    if (o_sum_energy !== exp_t.se) begin
                        $error("sum_energy exp %0h got %0h", exp_t.se, o_sum_energy);
                        errors++;
                    end
                    if (o_sum_energy_squared !== exp_t.se2) begin
                        $error("sum_energy_squared exp %0h got %0h", exp_t.se2,
                               o_sum_energy_squared);
                        errors++;
                    end
                    if (o_source_total !== exp_t.src) begin
                        $error("source_total exp %0h got %0h", exp_t.src, o_source_total);
                        errors++;
                    end
                    if (o_saturated !== exp_t.sat) begin
                        $error("saturated exp %0b got %0b", exp_t.sat, o_saturated);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0)
                i_ready <= 1'b0;
            else if (phase_now() == 2)
                i_ready <= ($urandom_range(0, 99) >= 76);
            else if (phase_now() == 3)
                i_ready <= ($urandom_range(0, 99) >= 32);
            else
                i_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // generator shadow: keeps sort sweeps and footprint size in budget
    bit gen_hit [int];
    int gen_cnt    = 0;
    bit gen_dirty  = 1'b0;
    int sorts_left = 9;

    task automatic add_req(logic [2:0] rt, logic [15:0] vox, logic [15:0] wt,
                           logic [31:0] en, logic [23:0] sc, logic [15:0] pos,
                           bit drain);
        t_req r;
        r = '{rt, vox, wt, en, sc, pos, drain};
        if (rt == vet_pkg::REQ_DEPOSIT && !gen_hit.exists(int'(vox))) begin
            gen_hit[int'(vox)] = 1'b1;
            gen_cnt++;
            gen_dirty = 1'b1;
        end else if (rt == vet_pkg::REQ_RESET) begin
            gen_hit.delete();
            gen_cnt   = 0;
            gen_dirty = 1'b0;
        end else if (rt == vet_pkg::REQ_LIST) begin
            if (gen_dirty)
                sorts_left--;
            gen_dirty = 1'b0;
        end
        pending_reqs.push_back(r);
    endtask

    initial begin
        int          r;
        logic [2:0]  rt;
        logic [15:0] vox;
        logic [15:0] pos;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_req_type = '0;
        i_voxel = '0;
        i_weight = '0;
        i_energy = '0;
        i_scale = '0;
        i_list_position = '0;

        // directed: field extremes, every request, list edge cases
        add_req(vet_pkg::REQ_DEPOSIT, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 24'd0, 16'd0, 0);
        add_req(vet_pkg::REQ_DEPOSIT, 16'hFFFF, 16'd0, 32'd0, 24'd0, 16'd0, 0);  // zero deposit
        add_req(vet_pkg::REQ_DEPOSIT, 16'h8000, 16'h4000, 32'h0001_0000, 24'd0, 16'd0, 0);
        add_req(vet_pkg::REQ_DEPOSIT, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 16'hFFFF, 0);
        add_req(vet_pkg::REQ_SOURCE, 16'd0, 16'd0, 32'hFFFF_FFFF, 24'd0, 16'd0, 0);
        add_req(vet_pkg::REQ_SUMS, 16'd0, 16'd0, 32'd0, 24'd0, 16'd0, 0);
        add_req(vet_pkg::REQ_LIST, 16'd0, 16'd0, 32'd0, 24'd0, 16'd0, 0);
        add_req(vet_pkg::REQ_LIST, 16'd0, 16'd0, 32'd0, 24'd0, 16'd2, 0);
        add_req(vet_pkg::REQ_LIST, 16'd0, 16'd0, 32'd0, 24'd0, 16'd3, 0);       // past count
        add_req(vet_pkg::REQ_LIST, 16'd0, 16'd0, 32'd0, 24'd0, 16'hFFFF, 0);
        add_req(vet_pkg::REQ_ACCUM, 16'd0, 16'd0, 32'd0, 24'hFFFFFF, 16'd0, 0);
        add_req(vet_pkg::REQ_SUMS, 16'd0, 16'd0, 32'd0, 24'd0, 16'd0, 0);
        add_req(vet_pkg::REQ_SUMS, 16'hFFFF, 16'd0, 32'd0, 24'd0, 16'd0, 0);
        add_req(vet_pkg::REQ_SUMS, 16'h8000, 16'd0, 32'd0, 24'd0, 16'd0, 0);
        add_req(vet_pkg::REQ_ACCUM, 16'd0, 16'd0, 32'd0, 24'd0, 16'd0, 0);
        add_req(3'd6, 16'h1234, 16'h5678, 32'h9ABC_DEF0, 24'h123456, 16'd1, 0);
        add_req(3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 16'hFFFF, 0);
        add_req(vet_pkg::REQ_RESET, 16'd0, 16'd0, 32'd0, 24'd0, 16'd0, 0);
        add_req(vet_pkg::REQ_SUMS, 16'd0, 16'd0, 32'd0, 24'd0, 16'd0, 0);
        add_req(vet_pkg::REQ_LIST, 16'd0, 16'd0, 32'd0, 24'd0, 16'd0, 0);        // empty list
        add_req(vet_pkg::REQ_SOURCE, 16'd0, 16'd0, 32'd1, 24'd0, 16'd0, 1);

        // drive one voxel's energy sum into saturation
        for (int k = 0; k < 18; k++) begin
            for (int j = 0; j < 4; j++)
                add_req(vet_pkg::REQ_DEPOSIT, 16'd5, 16'hFFFF, 32'hFFFF_FFFF, 24'd0,
                        16'd0, 0);
            add_req(vet_pkg::REQ_ACCUM, 16'd0, 16'd0, 32'd0, 24'hFFFFFF, 16'd0, 0);
        end
        add_req(vet_pkg::REQ_SUMS, 16'd5, 16'd0, 32'd0, 24'd0, 16'd0, 0);
        add_req(vet_pkg::REQ_RESET, 16'd0, 16'd0, 32'd0, 24'd0, 16'd0, 0);

        // random traffic, mostly on a small pool of voxels
        for (int i = 0; i < N_RANDOM; i++) begin
            r   = $urandom_range(0, 99);
            pos = (gen_cnt > 0 && $urandom_range(0, 3) != 0)
                  ? 16'($urandom_range(0, gen_cnt - 1)) : 16'($urandom);
            if ($urandom_range(0, 4) == 0)
                vox = 16'($urandom);
            else if ($urandom_range(0, 9) == 0)
                vox = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;
            else
                vox = 16'($urandom_range(0, 15));
            if (r < 50)      rt = vet_pkg::REQ_DEPOSIT;
            else if (r < 58) rt = vet_pkg::REQ_SOURCE;
            else if (r < 64) rt = vet_pkg::REQ_ACCUM;
            else if (r < 72) rt = vet_pkg::REQ_LIST;
            else if (r < 88) rt = vet_pkg::REQ_SUMS;
            else if (r < 92) rt = vet_pkg::REQ_RESET;
            else             rt = 3'($urandom_range(6, 7));
            if (rt == vet_pkg::REQ_DEPOSIT && gen_cnt > 40)
                rt = vet_pkg::REQ_RESET;
            if (rt == vet_pkg::REQ_LIST && gen_dirty && sorts_left <= 0)
                rt = vet_pkg::REQ_SUMS;
            add_req(rt, vox, 16'($urandom), 32'($urandom), 24'($urandom), pos,
                    (i % 250) == 249);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_reqs.size() == 0 && !i_valid && tally_expect.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && tally_expect.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: sim.f
rtl/vet_pkg.sv
rtl/vet_ram.sv
rtl/voxel_energy_tally_with_footprint.sv
sim/tb.sv
